// ===== design/rre_pkg.sv =====
// Package for the RPN relocation expression evaluator.
// Holds opcodes, event kinds, widths and the front-to-back token type.
`timescale 1ns / 1ps

package rre_pkg;

  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] OP_END = 8'h00;
  localparam logic [7:0] OP_ADD = 8'h01;
  localparam logic [7:0] OP_SUB = 8'h02;
  localparam logic [7:0] OP_MUL = 8'h03;
  localparam logic [7:0] OP_DIV = 8'h04;
  localparam logic [7:0] OP_MOD = 8'h05;
  localparam logic [7:0] OP_NEG = 8'h06;
  localparam logic [7:0] OP_SHIFT = 8'h07;
  localparam logic [7:0] OP_LAND = 8'h08;
  localparam logic [7:0] OP_LOR = 8'h09;
  localparam logic [7:0] OP_LXOR = 8'h0A;
  localparam logic [7:0] OP_LNOT = 8'h0B;
  localparam logic [7:0] OP_LE = 8'h0C;
  localparam logic [7:0] OP_GE = 8'h0D;
  localparam logic [7:0] OP_NE = 8'h0E;
  localparam logic [7:0] OP_LT = 8'h0F;
  localparam logic [7:0] OP_GT = 8'h10;
  localparam logic [7:0] OP_EQ = 8'h11;
  localparam logic [7:0] OP_AND = 8'h12;
  localparam logic [7:0] OP_OR = 8'h13;
  localparam logic [7:0] OP_XOR = 8'h14;
  localparam logic [7:0] OP_NOT = 8'h15;
  localparam logic [7:0] OP_PC = 8'h80;
  localparam logic [7:0] OP_CONST = 8'h81;
  localparam logic [7:0] OP_WEAK = 8'h82;
  localparam logic [7:0] OP_STRONG = 8'h83;
  localparam logic [7:0] OP_SYM_LAST = 8'h86;
  localparam logic [7:0] OP_SEGDISP = 8'h87;

  localparam int unsigned CFG_RESOLVE = 0;
  localparam int unsigned CFG_SEG_START = 1;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    EV_FINAL = 2'd0,
    EV_REQUEST = 2'd1,
    EV_UNDEF = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    CL_OPER,
    CL_PUSH,
    CL_EVENT_PUSH,
    CL_END
  } tok_class_t;

  typedef struct packed {
    tok_class_t  cls;
    logic [7:0]  op;
    logic [31:0] val;
    logic        rel;
    logic        seg_upd;
    logic [15:0] seg;
    event_kind_t kind;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_B,
    ST_POP_A,
    ST_EXEC,
    ST_DIV,
    ST_PUSH,
    ST_TOP,
    ST_EMIT
  } be_state_t;

endpackage

// ===== design/rre_if.sv =====
// Valid/ready stream interfaces for the evaluator's token and result channels.
// Depends on nothing.
`timescale 1ns / 1ps

interface rre_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [31:0] const_operand;
  logic [31:0] current_pc;
  logic        sym_resolved;
  logic        sym_absolute;
  logic [31:0] sym_value;
  logic [15:0] sym_segment;
  modport source(output valid, opcode, const_operand, current_pc, sym_resolved,
                 sym_absolute, sym_value, sym_segment, input ready);
  modport sink(input valid, opcode, const_operand, current_pc, sym_resolved,
               sym_absolute, sym_value, sym_segment, output ready);
endinterface

interface rre_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] value;
  logic        needs_reloc;
  logic [15:0] segment;
  logic [15:0] shift_amount;
  logic [31:0] unshifted_value;
  modport source(output valid, event_kind, value, needs_reloc, segment, shift_amount,
                 unshifted_value, input ready);
  modport sink(input valid, event_kind, value, needs_reloc, segment, shift_amount,
               unshifted_value, output ready);
endinterface

// ===== design/rre_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module rre_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rre_front.sv =====
// Front end: accepts tokens, classifies them and resolves push values.
// Depends on rre_pkg and rre_if.
`timescale 1ns / 1ps

module rre_front (
  rre_in_if.sink                in_ch,
  input  logic                  resolve_phase,
  input  logic [31:0]           seg_start,
  input  logic                  q_full,
  output logic                  q_push,
  output rre_pkg::tok_t         q_tok
);

  logic [7:0] op;
  logic       is_sym;

  assign op = in_ch.opcode;
  assign is_sym = (op >= rre_pkg::OP_WEAK) && (op <= rre_pkg::OP_SYM_LAST);
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  always_comb begin
    q_tok = '0;
    q_tok.op = op;
    q_tok.kind = rre_pkg::EV_FINAL;
    if (op >= rre_pkg::OP_ADD && op <= rre_pkg::OP_NOT) begin
      q_tok.cls = rre_pkg::CL_OPER;
    end else if (op == rre_pkg::OP_PC) begin
      q_tok.cls = rre_pkg::CL_PUSH;
      q_tok.val = in_ch.current_pc;
    end else if (op == rre_pkg::OP_CONST) begin
      q_tok.cls = rre_pkg::CL_PUSH;
      q_tok.val = in_ch.const_operand;
    end else if (op == rre_pkg::OP_SEGDISP) begin
      q_tok.cls = rre_pkg::CL_PUSH;
      q_tok.val = seg_start + in_ch.const_operand;
      q_tok.rel = 1'b1;
    end else if (is_sym && in_ch.sym_resolved) begin
      q_tok.cls = rre_pkg::CL_PUSH;
      q_tok.val = in_ch.sym_value;
      q_tok.rel = !in_ch.sym_absolute;
      q_tok.seg_upd = !in_ch.sym_absolute;
      q_tok.seg = in_ch.sym_segment;
    end else if (is_sym) begin
      q_tok.cls = rre_pkg::CL_PUSH;
      if (op != rre_pkg::OP_WEAK && !resolve_phase) begin
        q_tok.cls = rre_pkg::CL_EVENT_PUSH;
        q_tok.kind = rre_pkg::EV_REQUEST;
      end else if (op == rre_pkg::OP_STRONG && resolve_phase) begin
        q_tok.cls = rre_pkg::CL_EVENT_PUSH;
        q_tok.kind = rre_pkg::EV_UNDEF;
      end
    end else begin
      q_tok.cls = rre_pkg::CL_END;
    end
  end

endmodule

// ===== design/rre_queue.sv =====
// Short token queue between the front end and the execution back end.
// Depends on rre_pkg.
`timescale 1ns / 1ps

module rre_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rre_pkg::tok_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rre_pkg::tok_t dout
);

  localparam int unsigned PtrW = $clog2(rre_pkg::QueueDepth);

  rre_pkg::tok_t   buf_r [rre_pkg::QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full = (cnt_r == (PtrW+1)'(rre_pkg::QueueDepth));
  assign empty = (cnt_r == '0);
  assign dout = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== design/rre_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module rre_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] q_r, d_r, r_r;
  logic [5:0]  cnt_r;
  logic        busy_r, nq_r, nr_r;
  logic [32:0] trial;
  logic [31:0] r_sh;

  assign r_sh = {r_r[30:0], q_r[31]};
  assign trial = {1'b0, r_sh} - {1'b0, d_r};
  assign done = busy_r && (cnt_r == 6'd0);
  assign quo = nq_r ? (32'd0 - q_r) : q_r;
  assign rem = nr_r ? (32'd0 - r_r) : r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd32;
    end else if (busy_r && cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= a[31] ? (32'd0 - a) : a;
      d_r <= b[31] ? (32'd0 - b) : b;
      r_r <= '0;
      nq_r <= a[31] ^ b[31];
      nr_r <= a[31];
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!trial[32]) begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= r_sh;
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/rre_back.sv =====
// Back end: runs queued tokens against the value stack and emits results.
// Depends on rre_pkg, rre_if, rre_ram and rre_div.
`timescale 1ns / 1ps

module rre_back #(
  parameter int unsigned StackDepth = rre_pkg::StackDepthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  rre_pkg::tok_t q_tok,
  output logic          q_pop,
  rre_out_if.source     out_ch
);

  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);

  rre_pkg::be_state_t st_r, st_nxt;
  rre_pkg::tok_t      tok_r, tok_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [StackDepth-1:0] rel_r, rel_nxt;
  logic [15:0]        lseg_r, lseg_nxt;
  logic               sseen_r, sseen_nxt;
  logic [15:0]        scnt_r, scnt_nxt;
  logic [31:0]        ssrc_r, ssrc_nxt;
  logic [31:0]        a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic               ar_r, ar_nxt, br_r, br_nxt, rr_r, rr_nxt;
  logic               pa_r, pa_nxt, pb_r, pb_nxt;
  logic               dv_r, dv_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         ok_r, ok_nxt;
  logic [31:0]        ov_val_r, ov_val_nxt, ous_r, ous_nxt;
  logic               ov_rel_r, ov_rel_nxt;
  logic [15:0]        ov_seg_r, ov_seg_nxt, ov_sh_r, ov_sh_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          div_start, div_done;
  logic [31:0]   quo, rem;
  logic          unary;
  logic [63:0]   prod;

  rre_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rre_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(a_r), .b(b_r),
    .done(div_done), .quo(quo), .rem(rem)
  );

  assign unary = (tok_r.op == rre_pkg::OP_NEG) || (tok_r.op == rre_pkg::OP_LNOT) ||
                 (tok_r.op == rre_pkg::OP_NOT);
  assign prod = a_r * b_r;

  assign out_ch.valid = ov_r;
  assign out_ch.event_kind = ok_r;
  assign out_ch.value = ov_val_r;
  assign out_ch.needs_reloc = ov_rel_r;
  assign out_ch.segment = ov_seg_r;
  assign out_ch.shift_amount = ov_sh_r;
  assign out_ch.unshifted_value = ous_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rre_pkg::ST_IDLE;
      cnt_r <= '0;
      rel_r <= '0;
      lseg_r <= '0;
      sseen_r <= 1'b0;
      scnt_r <= '0;
      ssrc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      rel_r <= rel_nxt;
      lseg_r <= lseg_nxt;
      sseen_r <= sseen_nxt;
      scnt_r <= scnt_nxt;
      ssrc_r <= ssrc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    ar_r <= ar_nxt;
    br_r <= br_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    dv_r <= dv_nxt;
    res_r <= res_nxt;
    rr_r <= rr_nxt;
    ok_r <= ok_nxt;
    ov_val_r <= ov_val_nxt;
    ov_rel_r <= ov_rel_nxt;
    ov_seg_r <= ov_seg_nxt;
    ov_sh_r <= ov_sh_nxt;
    ous_r <= ous_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    tok_nxt = tok_r;
    cnt_nxt = cnt_r;
    rel_nxt = rel_r;
    lseg_nxt = lseg_r;
    sseen_nxt = sseen_r;
    scnt_nxt = scnt_r;
    ssrc_nxt = ssrc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    ar_nxt = ar_r;
    br_nxt = br_r;
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    dv_nxt = dv_r;
    res_nxt = res_r;
    rr_nxt = rr_r;
    ov_nxt = ov_r && !out_ch.ready;
    ok_nxt = ok_r;
    ov_val_nxt = ov_val_r;
    ov_rel_nxt = ov_rel_r;
    ov_seg_nxt = ov_seg_r;
    ov_sh_nxt = ov_sh_r;
    ous_nxt = ous_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = res_r;
    raddr = '0;
    div_start = 1'b0;
    unique case (st_r)
      rre_pkg::ST_IDLE: begin
        if (!q_empty && !ov_nxt) begin
          q_pop = 1'b1;
          tok_nxt = q_tok;
          res_nxt = q_tok.val;
          rr_nxt = q_tok.rel;
          b_nxt = '0;
          br_nxt = 1'b0;
          dv_nxt = 1'b0;
          unique case (q_tok.cls)
            rre_pkg::CL_OPER: begin
              st_nxt = rre_pkg::ST_POP_B;
            end
            rre_pkg::CL_PUSH: begin
              if (q_tok.seg_upd) begin
                lseg_nxt = q_tok.seg;
              end
              st_nxt = rre_pkg::ST_PUSH;
            end
            rre_pkg::CL_EVENT_PUSH: begin
              ov_nxt = 1'b1;
              ok_nxt = q_tok.kind;
              ov_val_nxt = '0;
              ov_rel_nxt = 1'b0;
              ov_seg_nxt = '0;
              ov_sh_nxt = '0;
              ous_nxt = '0;
              st_nxt = rre_pkg::ST_PUSH;
            end
            rre_pkg::CL_END: begin
              st_nxt = rre_pkg::ST_TOP;
            end
            default: st_nxt = rre_pkg::ST_IDLE;
          endcase
        end
      end
      rre_pkg::ST_POP_B: begin
        if (unary) begin
          st_nxt = rre_pkg::ST_POP_A;
        end else begin
          pb_nxt = (cnt_r != '0);
          br_nxt = rel_r[0];
          rel_nxt = rel_r >> 1;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            raddr = AW'(cnt_r - 1'b1);
          end
          st_nxt = rre_pkg::ST_POP_A;
        end
      end
      rre_pkg::ST_POP_A: begin
        if (!unary) begin
          b_nxt = pb_r ? rdata : '0;
        end
        pa_nxt = (cnt_r != '0);
        ar_nxt = rel_r[0];
        rel_nxt = rel_r >> 1;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          raddr = AW'(cnt_r - 1'b1);
        end
        st_nxt = rre_pkg::ST_EXEC;
      end
      rre_pkg::ST_EXEC: begin
        a_nxt = pa_r ? rdata : '0;
        st_nxt = rre_pkg::ST_DIV;
      end
      rre_pkg::ST_DIV: begin
        rr_nxt = 1'b0;
        st_nxt = rre_pkg::ST_PUSH;
        unique case (tok_r.op)
          rre_pkg::OP_ADD: begin
            res_nxt = a_r + b_r;
            rr_nxt = ar_r | br_r;
          end
          rre_pkg::OP_SUB: begin
            res_nxt = a_r - b_r;
            rr_nxt = (ar_r && br_r) ? 1'b0 : (ar_r | br_r);
          end
          rre_pkg::OP_MUL: res_nxt = prod[31:0];
          rre_pkg::OP_DIV, rre_pkg::OP_MOD: begin
            res_nxt = '0;
            if (b_r != '0) begin
              if (!dv_r) begin
                div_start = 1'b1;
                dv_nxt = 1'b1;
                st_nxt = rre_pkg::ST_DIV;
              end else if (div_done) begin
                res_nxt = (tok_r.op == rre_pkg::OP_DIV) ? quo : rem;
              end else begin
                st_nxt = rre_pkg::ST_DIV;
              end
            end
          end
          rre_pkg::OP_NEG: res_nxt = 32'd0 - a_r;
          rre_pkg::OP_SHIFT: begin
            ssrc_nxt = a_r;
            scnt_nxt = b_r[15:0];
            sseen_nxt = 1'b1;
            rr_nxt = ar_r;
            if (!b_r[31]) begin
              res_nxt = (b_r[30:5] != '0) ? '0 : (a_r << b_r[4:0]);
            end else begin
              res_nxt = (b_r[30:5] != '1 || b_r[4:0] == '0) ? '0 :
                        (a_r >> (5'd0 - b_r[4:0]));
            end
          end
          rre_pkg::OP_LAND: res_nxt = {31'd0, (a_r != '0) && (b_r != '0)};
          rre_pkg::OP_LOR: res_nxt = {31'd0, (a_r != '0) || (b_r != '0)};
          rre_pkg::OP_LXOR: res_nxt = {31'd0, (a_r != '0) != (b_r != '0)};
          rre_pkg::OP_LNOT: res_nxt = {31'd0, a_r == '0};
          rre_pkg::OP_LE: res_nxt = {31'd0, $signed(a_r) <= $signed(b_r)};
          rre_pkg::OP_GE: res_nxt = {31'd0, $signed(a_r) >= $signed(b_r)};
          rre_pkg::OP_NE: res_nxt = {31'd0, a_r != b_r};
          rre_pkg::OP_LT: res_nxt = {31'd0, $signed(a_r) < $signed(b_r)};
          rre_pkg::OP_GT: res_nxt = {31'd0, $signed(a_r) > $signed(b_r)};
          rre_pkg::OP_EQ: res_nxt = {31'd0, a_r == b_r};
          rre_pkg::OP_AND: res_nxt = a_r & b_r;
          rre_pkg::OP_OR: res_nxt = a_r | b_r;
          rre_pkg::OP_XOR: res_nxt = a_r ^ b_r;
          default: res_nxt = ~a_r;
        endcase
      end
      rre_pkg::ST_PUSH: begin
        if (cnt_r < CW'(StackDepth)) begin
          we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rel_nxt = {rel_r[StackDepth-2:0], rr_r};
        end
        st_nxt = rre_pkg::ST_IDLE;
      end
      rre_pkg::ST_TOP: begin
        raddr = AW'(cnt_r - 1'b1);
        st_nxt = rre_pkg::ST_EMIT;
      end
      rre_pkg::ST_EMIT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          ok_nxt = rre_pkg::EV_FINAL;
          ov_val_nxt = (cnt_r != '0) ? rdata : '0;
          ov_rel_nxt = rel_r[0];
          ov_seg_nxt = rel_r[0] ? lseg_r : '0;
          ov_sh_nxt = sseen_r ? scnt_r : '0;
          ous_nxt = sseen_r ? ssrc_r : ((cnt_r != '0) ? rdata : '0);
          cnt_nxt = '0;
          rel_nxt = '0;
          lseg_nxt = '0;
          sseen_nxt = 1'b0;
          scnt_nxt = '0;
          ssrc_nxt = '0;
          st_nxt = rre_pkg::ST_IDLE;
        end else begin
          raddr = AW'(cnt_r - 1'b1);
        end
      end
      default: st_nxt = rre_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/rpn_reloc_expression_evaluator.sv =====
// Top level of the RPN relocation expression evaluator.
// Depends on rre_pkg, rre_if, rre_front, rre_queue and rre_back.
//
// Usage: tokens arrive on the in_ channel (valid/ready), one per accept. The
// front end classifies each token and resolves push values into a two-entry
// queue; the back end runs it against a stack RAM and drives the out_ channel.
// A push token passes idle and push; an operator also passes pop-B, pop-A, exec
// and div, where divide or modulo by a nonzero value waits on the bit-serial
// divider. Terminator and unknown opcodes emit a final result via top and emit;
// symbol events are registered on leaving the queue. One output register holds
// a result until out_ready; while it is held the back end stops taking tokens
// and the queue fills, then in_ready drops. Reset clears the stack count,
// relocation bits, shift record and both config registers.
// cfg_ registers: index 0 resolve_phase, index 1 segment_start_pc; write only
// while idle.
`timescale 1ns / 1ps

module rpn_reloc_expression_evaluator #(
  parameter int unsigned StackDepth = rre_pkg::StackDepthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rre_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_wdata,
  rre_in_if.sink                      in_ch,
  rre_out_if.source                   out_ch
);

  logic          resolve_r;
  logic [31:0]   seg_start_r;
  logic          q_full, q_empty, q_push, q_pop;
  rre_pkg::tok_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolve_r <= 1'b0;
      seg_start_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rre_pkg::CfgIdxW'(rre_pkg::CFG_RESOLVE)) begin
        resolve_r <= cfg_wdata[0];
      end else begin
        seg_start_r <= cfg_wdata;
      end
    end
  end

  rre_front u_front (
    .in_ch(in_ch), .resolve_phase(resolve_r),
    .seg_start(seg_start_r), .q_full(q_full), .q_push(q_push), .q_tok(q_in)
  );

  rre_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_out)
  );

  rre_back #(.StackDepth(StackDepth)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_tok(q_out), .q_pop(q_pop),
    .out_ch(out_ch)
  );

endmodule

// ===== design/rre_checker.sv =====
// Port-level checker for the evaluator, bound to the top level.
// Depends on rre_pkg and the top level's ports.
`timescale 1ns / 1ps

module rre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_kind,
  input logic       out_needs_reloc,
  input logic [15:0] out_segment,
  input logic [31:0] out_value
);

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind != 2'd3)) else $error("bad event kind");

  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_needs_reloc |-> out_segment == '0) else $error("segment without reloc");

  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != rre_pkg::EV_FINAL |-> out_value == '0 && !out_needs_reloc)
    else $error("event fields nonzero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("result dropped");

endmodule

bind rpn_reloc_expression_evaluator rre_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_event_kind(out_ch.event_kind), .out_needs_reloc(out_ch.needs_reloc),
  .out_segment(out_ch.segment), .out_value(out_ch.value)
);
